// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge
`define RAT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent at the same edge
`define RAT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/rat_pkg.sv
// ---------------------------------------------------------------------------
// rat_pkg
// Shared constants, types and helpers of the repeating alarm timer.
// ---------------------------------------------------------------------------
`default_nettype none

package rat_pkg;

  localparam int TIME_WIDTH = 24;
  localparam int REM_W      = TIME_WIDTH + 2;
  localparam int OVS_W      = 24;
  localparam int FRAC_W     = 16;
  localparam int INT_W      = OVS_W - FRAC_W;
  localparam int CMP_W      = TIME_WIDTH + INT_W;
  localparam int CMD_W      = 3;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int DCNT_W     = $clog2(OVS_W);
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESET = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PAUSE = 3'd4;

  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_REPEAT = 1'b1;

  localparam logic [TIME_WIDTH-1:0] PERIOD_RESET = TIME_WIDTH'(1000);
  localparam logic [OVS_W-1:0]      OVS_SAT      = '1;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_START,
    OP_STOP,
    OP_RESET,
    OP_PAUSE,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [TIME_WIDTH-1:0] amount;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHECK,
    BK_DIV
  } back_state_t;

  // saturate a sum one bit wider than the remaining-time range to that range
  function automatic logic [REM_W-1:0] sat_rem(input logic [REM_W:0] v);
    logic [REM_W-1:0] r;
    if (v[REM_W] != v[REM_W-1]) begin
      r = v[REM_W] ? {1'b1, {(REM_W-1){1'b0}}} : {1'b0, {(REM_W-1){1'b1}}};
    end else begin
      r = v[REM_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rat_if.sv
// ---------------------------------------------------------------------------
// rat_if
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface rat_in_if;
  logic                            valid;
  logic                            ready;
  logic [rat_pkg::CMD_W-1:0]       cmd;
  logic [rat_pkg::TIME_WIDTH-1:0]  amount;

  modport source (output valid, cmd, amount, input ready);
  modport sink (input valid, cmd, amount, output ready);
endinterface

interface rat_out_if;
  logic                        valid;
  logic                        ready;
  logic                        fired;
  logic [rat_pkg::OVS_W-1:0]   oversleep;
  logic                        counted;
  logic                        is_running;

  modport source (output valid, fired, oversleep, counted, is_running, input ready);
  modport sink (input valid, fired, oversleep, counted, is_running, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rat_front.sv
// ---------------------------------------------------------------------------
// rat_front
// Accepts command transactions, decodes them and queues them for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module rat_front (
  input  wire logic   clk,
  input  wire logic   rst,
  rat_in_if.sink      item,
  input  wire logic   pop,
  output rat_pkg::q_t q
);

  rat_pkg::item_t                 entries [rat_pkg::QDEPTH];
  logic [rat_pkg::QPTR_W-1:0]     wr_ptr;
  logic [rat_pkg::QPTR_W-1:0]     rd_ptr;
  logic [rat_pkg::QCNT_W-1:0]     count;
  rat_pkg::item_t                 decoded;
  logic                           push;

  always_comb begin
    decoded.amount = item.amount;
    unique case (item.cmd)
      rat_pkg::CMD_TICK:  decoded.op = rat_pkg::OP_TICK;
      rat_pkg::CMD_START: decoded.op = rat_pkg::OP_START;
      rat_pkg::CMD_STOP:  decoded.op = rat_pkg::OP_STOP;
      rat_pkg::CMD_RESET: decoded.op = rat_pkg::OP_RESET;
      rat_pkg::CMD_PAUSE: decoded.op = rat_pkg::OP_PAUSE;
      default:            decoded.op = rat_pkg::OP_NOP;
    endcase
  end

  assign item.ready = (count != rat_pkg::QCNT_W'(rat_pkg::QDEPTH));
  assign push       = item.valid && item.ready;
  assign q.valid    = (count != '0);
  assign q.item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == rat_pkg::QPTR_W'(rat_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == rat_pkg::QPTR_W'(rat_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rat_div.sv
// ---------------------------------------------------------------------------
// rat_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rat_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [rat_pkg::TIME_WIDTH-1:0]  rem_init,
  input  wire logic [rat_pkg::OVS_W-1:0]       dividend_lo,
  input  wire logic [rat_pkg::TIME_WIDTH-1:0]  divisor,
  output logic                                 done,
  output logic [rat_pkg::OVS_W-1:0]            quotient
);

  logic [rat_pkg::TIME_WIDTH-1:0] rem;
  logic [rat_pkg::TIME_WIDTH-1:0] dvsr;
  logic [rat_pkg::OVS_W-1:0]      shreg;
  logic [rat_pkg::DCNT_W-1:0]     cnt;
  logic                           busy;
  logic [rat_pkg::TIME_WIDTH:0]   trial;

  assign trial    = {rem, shreg[rat_pkg::OVS_W-1]} - {1'b0, dvsr};
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      dvsr  <= divisor;
      shreg <= dividend_lo;
      cnt   <= rat_pkg::DCNT_W'(rat_pkg::OVS_W - 1);
    end else if (busy) begin
      // remainder stays below the divisor, so a carry-out means no borrow
      if (!trial[rat_pkg::TIME_WIDTH] || rem[rat_pkg::TIME_WIDTH-1]) begin
        rem   <= trial[rat_pkg::TIME_WIDTH-1:0];
        shreg <= {shreg[rat_pkg::OVS_W-2:0], 1'b1};
      end else begin
        rem   <= {rem[rat_pkg::TIME_WIDTH-2:0], shreg[rat_pkg::OVS_W-1]};
        shreg <= {shreg[rat_pkg::OVS_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rat_back.sv
// ---------------------------------------------------------------------------
// rat_back
// Executes queued commands on the timer state and registers the result.
// ---------------------------------------------------------------------------
`default_nettype none

module rat_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rat_pkg::q_t                     q,
  output logic                                 pop,
  input  wire logic [rat_pkg::TIME_WIDTH-1:0]  period,
  input  wire logic                            repeat_mode,
  rat_out_if.source                            result
);

  localparam int RW = rat_pkg::REM_W;
  localparam int TW = rat_pkg::TIME_WIDTH;

  rat_pkg::back_state_t     state, state_next;
  logic [RW-1:0]            rem, rem_next;
  logic [RW-1:0]            over, over_next;
  logic                     skip, skip_next;
  logic                     running, running_next;
  logic                     out_valid, out_valid_next;
  logic                     fired_r, fired_next;
  logic                     counted_r, counted_next;
  logic                     run_r, run_r_next;
  logic [rat_pkg::OVS_W-1:0] ovs_r, ovs_next;

  logic [RW-1:0]            rem_sub;
  logic [RW-1:0]            mag;
  logic                     too_big;
  logic                     div_start;
  logic                     div_done;
  logic [rat_pkg::OVS_W-1:0] div_q;
  logic                     out_free;

  assign rem_sub = rat_pkg::sat_rem({rem[RW-1], rem} - {3'b000, q.item.amount});
  assign mag     = RW'(0) - over;
  assign too_big = rat_pkg::CMP_W'(mag) >= {period, rat_pkg::INT_W'(0)};

  assign out_free = !out_valid || result.ready;

  rat_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .rem_init    (TW'(mag[RW-1:rat_pkg::INT_W])),
    .dividend_lo ({mag[rat_pkg::INT_W-1:0], rat_pkg::FRAC_W'(0)}),
    .divisor     (period),
    .done        (div_done),
    .quotient    (div_q)
  );

  always_comb begin
    state_next     = state;
    rem_next       = rem;
    over_next      = over;
    skip_next      = skip;
    running_next   = running;
    out_valid_next = out_valid && !result.ready;
    fired_next     = fired_r;
    counted_next   = counted_r;
    run_r_next     = run_r;
    ovs_next       = ovs_r;
    pop            = 1'b0;
    div_start      = 1'b0;

    unique case (state)
      rat_pkg::BK_IDLE: begin
        if (q.valid && out_free) begin
          pop          = 1'b1;
          fired_next   = 1'b0;
          counted_next = 1'b0;
          ovs_next     = '0;
          unique case (q.item.op)
            rat_pkg::OP_TICK: begin
              if (running && skip) begin
                skip_next = 1'b0;
              end else if (running) begin
                counted_next = 1'b1;
                rem_next     = rem_sub;
                if (rem_sub[RW-1] || (rem_sub == '0)) begin
                  fired_next = 1'b1;
                  over_next  = rem_sub;
                  if (!repeat_mode) begin
                    running_next = 1'b0;
                  end
                end
              end
            end
            rat_pkg::OP_START: running_next = 1'b1;
            rat_pkg::OP_STOP:  running_next = 1'b0;
            rat_pkg::OP_RESET: begin
              rem_next     = {2'b00, period};
              skip_next    = 1'b1;
              running_next = 1'b0;
            end
            rat_pkg::OP_PAUSE: begin
              rem_next = rat_pkg::sat_rem({rem[RW-1], rem} + {3'b000, q.item.amount});
            end
            default: ;
          endcase
          run_r_next = running_next;
          if (fired_next) begin
            state_next = rat_pkg::BK_CHECK;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      rat_pkg::BK_CHECK: begin
        if (repeat_mode) begin
          rem_next = rat_pkg::sat_rem({over[RW-1], over} + {3'b000, period});
        end
        if (mag == '0) begin
          ovs_next       = '0;
          out_valid_next = 1'b1;
          state_next     = rat_pkg::BK_IDLE;
        end else if ((period == '0) || too_big) begin
          ovs_next       = rat_pkg::OVS_SAT;
          out_valid_next = 1'b1;
          state_next     = rat_pkg::BK_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = rat_pkg::BK_DIV;
        end
      end
      rat_pkg::BK_DIV: begin
        if (div_done) begin
          ovs_next       = div_q;
          out_valid_next = 1'b1;
          state_next     = rat_pkg::BK_IDLE;
        end
      end
      default: state_next = rat_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rat_pkg::BK_IDLE;
      rem       <= '0;
      skip      <= 1'b1;
      running   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rem       <= rem_next;
      skip      <= skip_next;
      running   <= running_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    over      <= over_next;
    fired_r   <= fired_next;
    counted_r <= counted_next;
    run_r     <= run_r_next;
    ovs_r     <= ovs_next;
  end

  assign result.valid      = out_valid;
  assign result.fired      = fired_r;
  assign result.counted    = counted_r;
  assign result.is_running = run_r;
  assign result.oversleep  = ovs_r;

endmodule

`default_nettype wire

// File: rtl/core/repeating_alarm_timer.sv
// A command that does not fire is queued, popped in the idle state and its result registered.
// A firing tick then holds the back end in a check state and the 24-step radix-2 divider.
// A saturated or zero oversleep skips the divider and is reported from the check state.
// Throughput: one command per cycle while results are taken and the back end is idle.
// A two-entry command queue keeps accepting until full while the back end works or the result stalls.
// Synchronous active-high rst: period 1000, one-shot, stopped, remaining 0, first tick skipped.
// ---------------------------------------------------------------------------
// repeating_alarm_timer
// Countdown alarm timer with auto reload, APB configuration and item channels.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module repeating_alarm_timer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rat_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [rat_pkg::DATA_W-1:0]    pwdata,
  output logic [rat_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  rat_in_if.sink                             item,
  rat_out_if.source                          result
);

  logic [rat_pkg::TIME_WIDTH-1:0] period;
  logic                           repeat_mode;
  logic                           pop;
  rat_pkg::q_t                    q;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period      <= rat_pkg::PERIOD_RESET;
      repeat_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == rat_pkg::REG_PERIOD) begin
        period <= pwdata[rat_pkg::TIME_WIDTH-1:0];
      end else begin
        repeat_mode <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == rat_pkg::REG_REPEAT) ?
                  {{(rat_pkg::DATA_W-1){1'b0}}, repeat_mode} :
                  {{(rat_pkg::DATA_W-rat_pkg::TIME_WIDTH){1'b0}}, period};

  rat_front u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .pop  (pop),
    .q    (q)
  );

  rat_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q           (q),
    .pop         (pop),
    .period      (period),
    .repeat_mode (repeat_mode),
    .result      (result)
  );

  `RAT_ASSERT(a_pop_needs_entry, !pop || q.valid, "pop from empty command queue")
  `RAT_ASSERT_IMPL(a_fired_counted, result.valid && result.fired, result.counted,
                   "fired result without an applied tick")
  `RAT_ASSERT_IMPL(a_ovs_only_fired, result.valid && (result.oversleep != '0), result.fired,
                   "oversleep reported without firing")
  `RAT_ASSERT_IMPL(a_oneshot_stops, result.valid && result.fired && !repeat_mode,
                   !result.is_running, "one-shot timer still running after firing")

endmodule

`default_nettype wire
